[rtl/acm_pkg.sv]
// acm_pkg: constants, types and helper functions of the argmax confusion matrix block
// no dependencies; used by the channel interfaces and by the top level
package acm_pkg;

    localparam int NUM_CLASSES = 32;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int ELEM_W      = CLASS_W + 1;
    localparam int SCORE_W     = 16;
    localparam int COUNT_W     = 32;
    localparam int CELL_AW     = 2 * CLASS_W;
    localparam int CELL_DEPTH  = NUM_CLASSES * NUM_CLASSES;

    typedef enum logic {
        REQ_SCORE = 1'b0,
        REQ_READ  = 1'b1
    } req_kind_t;

    typedef enum logic {
        RESP_SAMPLE = 1'b0,
        RESP_CELL   = 1'b1
    } resp_kind_t;

    // item held in the input register
    typedef struct packed {
        logic               req_type;
        logic [SCORE_W-1:0] score;
        logic [CLASS_W-1:0] true_label;
        logic               last_score;
        logic [CLASS_W-1:0] read_pred;
        logic [CLASS_W-1:0] read_label;
    } s1_t;

    // item in the cell update stage
    typedef struct packed {
        resp_kind_t         kind;
        logic               res;
        logic               wr;
        logic [CLASS_W-1:0] pred;
        logic               correct;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] corr;
        logic [CELL_AW-1:0] addr;
    } s2_t;

    // result waiting at the output
    typedef struct packed {
        resp_kind_t         kind;
        logic [CLASS_W-1:0] pred;
        logic               correct;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] corr;
        logic [COUNT_W-1:0] cell_cnt;
    } out_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        r = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

endpackage

[rtl/acm_if.sv]
// acm_in_if and acm_out_if: valid/ready channels for request and response items
// depends on acm_pkg for field widths
interface acm_in_if;
    import acm_pkg::*;

    logic               valid;
    logic               ready;
    logic               req_type;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] true_label;
    logic               last_score;
    logic [CLASS_W-1:0] read_pred;
    logic [CLASS_W-1:0] read_label;

    modport source (
        output valid, req_type, score, true_label, last_score, read_pred, read_label,
        input  ready
    );
    modport sink (
        input  valid, req_type, score, true_label, last_score, read_pred, read_label,
        output ready
    );
endinterface

interface acm_out_if;
    import acm_pkg::*;

    logic               valid;
    logic               ready;
    logic               resp_kind;
    logic [CLASS_W-1:0] predicted_class;
    logic               is_correct;
    logic [COUNT_W-1:0] total_count;
    logic [COUNT_W-1:0] correct_count;
    logic [COUNT_W-1:0] cell_count;

    modport source (
        output valid, resp_kind, predicted_class, is_correct, total_count, correct_count,
               cell_count,
        input  ready
    );
    modport sink (
        input  valid, resp_kind, predicted_class, is_correct, total_count, correct_count,
               cell_count,
        output ready
    );
endinterface

[rtl/argmax_confusion_matrix.sv]
// argmax_confusion_matrix: running argmax, 32x32 confusion matrix and accuracy counters
// registers: input, cell update, output; one item per cycle unless resp.ready stalls it
// the cell read-modify-write uses one write and one registered read port, with a bypass
// reset: after rst_n rises a clearing pass zeroes the 1024 cells, during which req.ready
// stays low; all counters and the argmax state reset to zero
// depends on acm_pkg, acm_in_if, acm_out_if
module argmax_confusion_matrix (
    input logic       clk,
    input logic       rst_n,
    acm_in_if.sink    req,
    acm_out_if.source resp
);
    import acm_pkg::*;

    logic [COUNT_W-1:0] mem [CELL_DEPTH];

    logic               clr_busy_reg, clr_busy_next;
    logic [CELL_AW-1:0] clr_addr_reg, clr_addr_next;

    logic               s1_valid_reg, s1_valid_next;
    s1_t                s1_reg;
    logic               s2_valid_reg, s2_valid_next;
    s2_t                s2_reg, s2_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg;

    logic [SCORE_W-1:0] best_score_reg, best_score_next;
    logic [CLASS_W-1:0] best_idx_reg, best_idx_next;
    logic [ELEM_W-1:0]  elem_idx_reg, elem_idx_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] corr_reg, corr_next;

    logic               fwd_reg, fwd_next;
    logic [COUNT_W-1:0] fwd_data_reg;
    logic [COUNT_W-1:0] rd_reg;

    logic               in_acc;
    logic               out_free, s2_adv, s2_ready, s1_adv, s1_ready;
    logic               s1_is_read, s1_close, elem_live, take, correct;
    logic [CLASS_W-1:0] pred;
    logic [SCORE_W-1:0] cand_score;
    logic [COUNT_W-1:0] tot_inc, corr_inc;
    logic [CELL_AW-1:0] s1_addr;
    logic [COUNT_W-1:0] cell_cur, cell_inc;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_wa;
    logic [COUNT_W-1:0] mem_wd;

    // handshake and stage movement
    always_comb
    begin
        out_free = !out_valid_reg || resp.ready;
        s2_adv   = s2_valid_reg && (out_free || !s2_reg.res);
        s2_ready = !s2_valid_reg || s2_adv;
        s1_adv   = s1_valid_reg && s2_ready;
        s1_ready = !s1_valid_reg || s1_adv;
    end

    assign req.ready = s1_ready && !clr_busy_reg;
    assign in_acc    = req.valid && req.ready;

    // argmax and counters on the item in the input register
    always_comb
    begin
        s1_is_read = (s1_reg.req_type == REQ_READ);
        s1_close   = !s1_is_read && s1_reg.last_score;
        elem_live  = (elem_idx_reg < ELEM_W'(NUM_CLASSES));
        take       = elem_live && ((elem_idx_reg == '0) || (s1_reg.score > best_score_reg));
        pred       = take ? elem_idx_reg[CLASS_W-1:0] : best_idx_reg;
        cand_score = take ? s1_reg.score : best_score_reg;
        correct    = (pred == s1_reg.true_label);
        tot_inc    = sat_inc(total_reg);
        corr_inc   = correct ? sat_inc(corr_reg) : corr_reg;
        s1_addr    = s1_is_read ? {s1_reg.read_pred, s1_reg.read_label}
                                : {pred, s1_reg.true_label};

        best_score_next = best_score_reg;
        best_idx_next   = best_idx_reg;
        elem_idx_next   = elem_idx_reg;
        total_next      = total_reg;
        corr_next       = corr_reg;
        if (s1_adv && !s1_is_read)
        begin
            if (s1_close)
            begin
                best_score_next = '0;
                best_idx_next   = '0;
                elem_idx_next   = '0;
                total_next      = tot_inc;
                corr_next       = corr_inc;
            end
            else
            begin
                best_score_next = cand_score;
                best_idx_next   = pred;
                elem_idx_next   = elem_live ? elem_idx_reg + 1'b1 : elem_idx_reg;
            end
        end

        s2_next.kind    = s1_is_read ? RESP_CELL : RESP_SAMPLE;
        s2_next.res     = s1_is_read || s1_close;
        s2_next.wr      = s1_close;
        s2_next.pred    = s1_is_read ? '0 : pred;
        s2_next.correct = !s1_is_read && correct;
        s2_next.total   = s1_close ? tot_inc : total_reg;
        s2_next.corr    = s1_close ? corr_inc : corr_reg;
        s2_next.addr    = s1_addr;
    end

    // cell update stage
    always_comb
    begin
        cell_cur = fwd_reg ? fwd_data_reg : rd_reg;
        cell_inc = sat_inc(cell_cur);
        fwd_next = s2_valid_reg && s2_adv && s2_reg.wr && (s2_reg.addr == s1_addr);
        mem_we   = clr_busy_reg || (s2_adv && s2_reg.wr);
        mem_wa   = clr_busy_reg ? clr_addr_reg : s2_reg.addr;
        mem_wd   = clr_busy_reg ? '0 : cell_inc;
    end

    // control next state
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {CELL_AW{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end

        s1_valid_next  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        out_valid_next = (s2_adv && s2_reg.res) ? 1'b1
                                                : (resp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            best_score_reg <= '0;
            best_idx_reg   <= '0;
            elem_idx_reg   <= '0;
            total_reg      <= '0;
            corr_reg       <= '0;
        end
        else
        begin
            clr_busy_reg   <= clr_busy_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= out_valid_next;
            best_score_reg <= best_score_next;
            best_idx_reg   <= best_idx_next;
            elem_idx_reg   <= elem_idx_next;
            total_reg      <= total_next;
            corr_reg       <= corr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg.req_type   <= req.req_type;
            s1_reg.score      <= req.score;
            s1_reg.true_label <= req.true_label;
            s1_reg.last_score <= req.last_score;
            s1_reg.read_pred  <= req.read_pred;
            s1_reg.read_label <= req.read_label;
        end
        if (s1_adv)
        begin
            s2_reg       <= s2_next;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= cell_inc;
        end
        if (s2_adv && s2_reg.res)
        begin
            out_reg.kind     <= s2_reg.kind;
            out_reg.pred     <= s2_reg.pred;
            out_reg.correct  <= s2_reg.correct;
            out_reg.total    <= s2_reg.total;
            out_reg.corr     <= s2_reg.corr;
            out_reg.cell_cnt <= s2_reg.wr ? cell_inc : cell_cur;
        end
    end

    // confusion cell store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (s1_adv)
        begin
            rd_reg <= mem[s1_addr];
        end
    end

    assign resp.valid           = out_valid_reg;
    assign resp.resp_kind       = out_reg.kind;
    assign resp.predicted_class = out_reg.pred;
    assign resp.is_correct      = out_reg.correct;
    assign resp.total_count     = out_reg.total;
    assign resp.correct_count   = out_reg.corr;
    assign resp.cell_count      = out_reg.cell_cnt;

endmodule
